/* hdl/rollback_union_find_unit_macros.svh */
// ----------------------------------------------------------------------------
// rollback union-find assertion macros
// shared property wrappers, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ROLLBACK_UNION_FIND_UNIT_MACROS_SVH
`define ROLLBACK_UNION_FIND_UNIT_MACROS_SVH

// same-cycle implication
`define RUF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RUF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ruf_pkg.sv */
// ----------------------------------------------------------------------------
// ruf_pkg
// types and constants shared by the rollback union-find unit
// ----------------------------------------------------------------------------
package ruf_pkg;

	localparam int NODES       = 1024;
	localparam int NODE_W      = $clog2(NODES);
	localparam int SIZE_W      = NODE_W + 1;
	localparam int STACK_DEPTH = NODES - 1;
	localparam int DEPTH_W     = NODE_W;
	localparam int CNT_W       = 11;

	localparam logic CMD_JOIN     = 1'b0;
	localparam logic CMD_ROLLBACK = 1'b1;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_SAME      = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [NODE_W-1:0] parent;
	} node_ent_t;

	typedef struct packed {
		logic [NODE_W-1:0] keep;
		logic [NODE_W-1:0] hung;
	} stk_ent_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		node_ent_t         wdata;
		logic [NODE_W-1:0] raddr;
	} node_req_t;

	typedef struct packed {
		logic               we;
		logic [DEPTH_W-1:0] waddr;
		stk_ent_t           wdata;
		logic [DEPTH_W-1:0] raddr;
	} stk_req_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         status;
		logic [DEPTH_W-1:0] depth;
	} res_t;

endpackage

/* hdl/ruf_ram.sv */
// ----------------------------------------------------------------------------
// ruf_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ruf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 21,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/ruf_alu.sv */
// ----------------------------------------------------------------------------
// ruf_alu
// shared size adder / subtractor, borrow doubles as the size compare
// ----------------------------------------------------------------------------
module ruf_alu
	import ruf_pkg::*;
(
	input  logic              op,
	input  logic [SIZE_W-1:0] a,
	input  logic [SIZE_W-1:0] b,
	output logic [SIZE_W-1:0] res,
	output logic              borrow
);

	logic [SIZE_W:0] full;

	always_comb begin
		if (op == ALU_SUB) begin
			full = {1'b0, a} - {1'b0, b};
		end else begin
			full = {1'b0, a} + {1'b0, b};
		end
	end

	assign res    = full[SIZE_W-1:0];
	assign borrow = (op == ALU_SUB) ? full[SIZE_W] : 1'b0;

endmodule

/* hdl/ruf_seq.sv */
// ----------------------------------------------------------------------------
// ruf_seq
// sequencer: table clear, root walks, union, rollback pops
// ----------------------------------------------------------------------------
`include "rollback_union_find_unit_macros.svh"

module ruf_seq
	import ruf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_cmd,
	input  logic [NODE_W-1:0]  in_a,
	input  logic [NODE_W-1:0]  in_b,
	input  logic [DEPTH_W-1:0] in_cnt,
	output node_req_t          node_req,
	input  node_ent_t          node_rdata,
	output stk_req_t           stk_req,
	input  stk_ent_t           stk_rdata,
	output logic               alu_op,
	output logic [SIZE_W-1:0]  alu_a,
	output logic [SIZE_W-1:0]  alu_b,
	input  logic [SIZE_W-1:0]  alu_res,
	input  logic               alu_borrow,
	output res_t               res,
	input  logic               res_take
);

	localparam logic [3:0] S_CLR        = 4'd0;
	localparam logic [3:0] S_IDLE       = 4'd1;
	localparam logic [3:0] S_WALK_A     = 4'd2;
	localparam logic [3:0] S_WALK_B     = 4'd3;
	localparam logic [3:0] S_CMP        = 4'd4;
	localparam logic [3:0] S_WR_HUNG    = 4'd5;
	localparam logic [3:0] S_WR_KEEP    = 4'd6;
	localparam logic [3:0] S_RB_POP     = 4'd7;
	localparam logic [3:0] S_RB_HUNG    = 4'd8;
	localparam logic [3:0] S_RB_KEEP    = 4'd9;
	localparam logic [3:0] S_RB_WR_KEEP = 4'd10;
	localparam logic [3:0] S_RB_WR_HUNG = 4'd11;
	localparam logic [3:0] S_DONE       = 4'd12;

	logic [3:0]         state_q;
	logic [NODE_W-1:0]  clr_q;
	logic [NODE_W-1:0]  pend_q;
	logic [NODE_W-1:0]  b_q;
	logic [NODE_W-1:0]  ra_q;
	logic [NODE_W-1:0]  rb_q;
	logic [SIZE_W-1:0]  sa_q;
	logic [SIZE_W-1:0]  sb_q;
	logic [NODE_W-1:0]  keep_q;
	logic [NODE_W-1:0]  hung_q;
	logic [SIZE_W-1:0]  ksize_q;
	logic [SIZE_W-1:0]  hsize_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] cnt_q;
	logic [1:0]         status_q;
	logic               at_root;

	assign in_ready   = (state_q == S_IDLE);
	assign at_root    = (node_rdata.parent == pend_q);
	assign res.valid  = (state_q == S_DONE);
	assign res.status = status_q;
	assign res.depth  = depth_q;

	// memory ports and the shared alu
	always_comb begin
		node_req = '0;
		node_req.raddr = pend_q;
		stk_req = '0;
		stk_req.waddr = depth_q;
		stk_req.wdata = '{keep: keep_q, hung: hung_q};
		stk_req.raddr = depth_q - DEPTH_W'(1);
		alu_op = ALU_ADD;
		alu_a  = ksize_q;
		alu_b  = hsize_q;
		unique case (state_q)
			S_CLR: begin
				node_req.we    = 1'b1;
				node_req.waddr = clr_q;
				node_req.wdata = '{size: SIZE_W'(1), parent: clr_q};
			end
			S_IDLE: begin
				node_req.raddr = in_a;
			end
			S_WALK_A: begin
				node_req.raddr = at_root ? b_q : node_rdata.parent;
			end
			S_WALK_B: begin
				node_req.raddr = node_rdata.parent;
			end
			S_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = sa_q;
				alu_b  = sb_q;
			end
			S_WR_HUNG: begin
				node_req.we    = 1'b1;
				node_req.waddr = hung_q;
				node_req.wdata = '{size: hsize_q, parent: keep_q};
				stk_req.we     = 1'b1;
			end
			S_WR_KEEP: begin
				node_req.we    = 1'b1;
				node_req.waddr = keep_q;
				node_req.wdata = '{size: alu_res, parent: keep_q};
			end
			S_RB_HUNG: begin
				node_req.raddr = stk_rdata.hung;
			end
			S_RB_KEEP: begin
				node_req.raddr = keep_q;
			end
			S_RB_WR_KEEP: begin
				alu_op = ALU_SUB;
				alu_a  = node_rdata.size;
				alu_b  = hsize_q;
				node_req.we    = 1'b1;
				node_req.waddr = keep_q;
				node_req.wdata = '{size: alu_res, parent: keep_q};
			end
			S_RB_WR_HUNG: begin
				node_req.we    = 1'b1;
				node_req.waddr = hung_q;
				node_req.wdata = '{size: hsize_q, parent: hung_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			depth_q  <= '0;
			cnt_q    <= '0;
			status_q <= ST_DONE;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (in_cmd == CMD_JOIN) begin
							state_q <= S_WALK_A;
						end else begin
							state_q <= S_RB_POP;
							if (in_cnt > depth_q) begin
								cnt_q    <= depth_q;
								status_q <= ST_UNDERFLOW;
							end else begin
								cnt_q    <= in_cnt;
								status_q <= ST_DONE;
							end
						end
					end
				end
				S_WALK_A: begin
					if (at_root) begin
						state_q <= S_WALK_B;
					end
				end
				S_WALK_B: begin
					if (at_root) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (ra_q == rb_q) begin
						status_q <= ST_SAME;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_WR_HUNG;
					end
				end
				S_WR_HUNG: begin
					depth_q <= depth_q + DEPTH_W'(1);
					state_q <= S_WR_KEEP;
				end
				S_WR_KEEP: begin
					status_q <= ST_DONE;
					state_q  <= S_DONE;
				end
				S_RB_POP: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						depth_q <= depth_q - DEPTH_W'(1);
						cnt_q   <= cnt_q - DEPTH_W'(1);
						state_q <= S_RB_HUNG;
					end
				end
				S_RB_HUNG:    state_q <= S_RB_KEEP;
				S_RB_KEEP:    state_q <= S_RB_WR_KEEP;
				S_RB_WR_KEEP: state_q <= S_RB_WR_HUNG;
				S_RB_WR_HUNG: state_q <= S_RB_POP;
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk and union datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pend_q <= in_a;
				b_q    <= in_b;
			end
			S_WALK_A: begin
				if (at_root) begin
					ra_q   <= pend_q;
					sa_q   <= node_rdata.size;
					pend_q <= b_q;
				end else begin
					pend_q <= node_rdata.parent;
				end
			end
			S_WALK_B: begin
				if (at_root) begin
					rb_q <= pend_q;
					sb_q <= node_rdata.size;
				end else begin
					pend_q <= node_rdata.parent;
				end
			end
			S_CMP: begin
				// smaller tree goes under the larger, b side on a tie
				if (alu_borrow) begin
					keep_q  <= rb_q;
					hung_q  <= ra_q;
					ksize_q <= sb_q;
					hsize_q <= sa_q;
				end else begin
					keep_q  <= ra_q;
					hung_q  <= rb_q;
					ksize_q <= sa_q;
					hsize_q <= sb_q;
				end
			end
			S_RB_HUNG: begin
				keep_q <= stk_rdata.keep;
				hung_q <= stk_rdata.hung;
			end
			S_RB_KEEP: begin
				hsize_q <= node_rdata.size;
			end
			default: begin
			end
		endcase
	end

	`RUF_ASSERT_NEXT(a_push_bumps_depth, stk_req.we, depth_q == $past(depth_q) + DEPTH_W'(1), "push without depth increment")
	`RUF_ASSERT_NOW(a_underflow_empties, res.valid && res.status == ST_UNDERFLOW, res.depth == '0, "underflow left entries on stack")
	`RUF_ASSERT_NEXT(a_pop_stops, state_q == S_RB_POP && cnt_q == '0, $stable(depth_q), "depth moved after last pop")
	`RUF_ASSERT_NOW(a_idle_no_write, in_ready, !node_req.we && !stk_req.we, "table write while idle")

endmodule

/* hdl/rollback_union_find_unit.sv */
// ----------------------------------------------------------------------------
// rollback_union_find_unit
// disjoint-set table, union by size, no path compression, undo stack
//
//  channel   dir  contents
//  s_axis    in   tuser: cmd; tdata: node_a, node_b, undo_count
//  m_axis    out  tdata: status, stack_depth, all_connected
//  cfg       in   node_count
//
//  a join walks the tree of node_a, then that of node_b, one node table read
//  a cycle; the tree depths are at most 10 each
//  a rollback undoes one popped union at a time: stack read, hung and keep
//  size reads, then keep and hung writes, one node table port per access
//  after reset every node table entry is cleared before s_tready rises
//  one beat in flight; s_tready stays low until its result is in the output
//  register, which holds under m_tready low
// ----------------------------------------------------------------------------
module rollback_union_find_unit
	import ruf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // node_a, node_b, undo_count, pad
	input  logic              s_tuser,   // cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // status, stack_depth, all_connected, pad
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data   // node_count
);

	node_req_t         node_req;
	node_ent_t         node_rdata;
	stk_req_t          stk_req;
	stk_ent_t          stk_rdata;
	logic              alu_op;
	logic [SIZE_W-1:0] alu_a;
	logic [SIZE_W-1:0] alu_b;
	logic [SIZE_W-1:0] alu_res;
	logic              alu_borrow;
	res_t              res;
	logic              res_take;
	logic              all_conn;
	logic [CNT_W-1:0]  node_count_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	ruf_ram #(
		.DEPTH(NODES),
		.WIDTH($bits(node_ent_t))
	) u_node_ram (
		.clk  (clk),
		.we   (node_req.we),
		.waddr(node_req.waddr),
		.wdata(node_req.wdata),
		.raddr(node_req.raddr),
		.rdata(node_rdata)
	);

	ruf_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH($bits(stk_ent_t))
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_req.we),
		.waddr(stk_req.waddr),
		.wdata(stk_req.wdata),
		.raddr(stk_req.raddr),
		.rdata(stk_rdata)
	);

	ruf_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.borrow(alu_borrow)
	);

	ruf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_a      (s_tdata[9:0]),
		.in_b      (s_tdata[19:10]),
		.in_cnt    (s_tdata[29:20]),
		.node_req  (node_req),
		.node_rdata(node_rdata),
		.stk_req   (stk_req),
		.stk_rdata (stk_rdata),
		.alu_op    (alu_op),
		.alu_a     (alu_a),
		.alu_b     (alu_b),
		.alu_res   (alu_res),
		.alu_borrow(alu_borrow),
		.res       (res),
		.res_take  (res_take)
	);

	assign cfg_ready = 1'b1;
	assign res_take  = res.valid && (!m_tvalid_q || m_tready);
	assign all_conn  = ((CNT_W'(res.depth) + CNT_W'(1)) == node_count_q);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(NODES);
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_data;
			end
			if (res_take) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {3'b000, all_conn, res.depth, res.status};
		end
	end

endmodule
